// ===== hw/rtl/chb_pkg.sv =====
`default_nettype none

package chb_pkg;

    localparam int CHUNK_W = 32;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

    typedef enum logic [4:0] {
        PH_SKIP = 5'b00001,
        PH_SIZE = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_DATA = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [CHUNK_W-1:0]   chunk_count;
        logic [COUNT_W-1:0]   delivered_count;
        logic                 dropped;
    } chb_state_t;

    typedef struct packed {
        logic                 data_valid;
        logic [BYTE_W-1:0]    data_byte;
        logic                 finished;
        logic                 truncated;
    } chb_result_t;

    localparam chb_state_t STATE_CLEAR = '{
        phase:           PH_SKIP,
        chunk_count:     '0,
        delivered_count: '0,
        dropped:         1'b0
    };

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // {is_hex, value}
    function automatic logic [DIGIT_W:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [DIGIT_W:0] r;
        r = '0;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            r = {1'b1, DIGIT_W'(c - 8'h30)};
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            r = {1'b1, DIGIT_W'(c - 8'h57)};
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            r = {1'b1, DIGIT_W'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/chb_in_if.sv =====
`default_nettype none

interface chb_in_if;
    import chb_pkg::*;

    logic              valid;
    logic              ready;
    logic              start_req;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output start_req, output in_byte, input ready);
    modport sink   (input valid, input start_req, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chb_out_if.sv =====
`default_nettype none

interface chb_out_if;
    import chb_pkg::*;

    logic              valid;
    logic              ready;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              finished;
    logic              truncated;

    modport source (output valid, output data_valid, output data_byte,
                    output finished, output truncated, input ready);
    modport sink   (input valid, input data_valid, input data_byte,
                    input finished, input truncated, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chb_step.sv =====
`default_nettype none

module chb_step
    import chb_pkg::*;
(
    input  chb_state_t         state,
    input  logic               start_req,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic [COUNT_W-1:0] output_limit,
    output chb_state_t         state_next,
    output chb_result_t        result
);

    chb_state_t         cur;
    chb_state_t         nxt;
    logic [DIGIT_W:0]   hex;
    logic               valid;
    logic [CHUNK_W-1:0] acc;

    assign hex = hex_decode(in_byte);

    // chunk*16 + digit, saturating when the top nibble would shift out
    assign acc = (cur.chunk_count[CHUNK_W-1 -: DIGIT_W] != '0) ? '1
               : {cur.chunk_count[CHUNK_W-DIGIT_W-1:0], hex[DIGIT_W-1:0]};

    always_comb
    begin
        cur   = start_req ? STATE_CLEAR : state;
        nxt   = cur;
        valid = 1'b0;
        if ((in_byte == CH_NUL) && (cur.phase != PH_DONE))
        begin
            nxt.phase = PH_DONE;
        end
        else
        begin
            unique case (cur.phase)
                PH_SKIP:
                begin
                    if (!is_space(in_byte))
                    begin
                        if (!hex[DIGIT_W])
                        begin
                            nxt.phase = PH_DONE;
                        end
                        else
                        begin
                            nxt.chunk_count = CHUNK_W'(hex[DIGIT_W-1:0]);
                            nxt.phase       = PH_SIZE;
                        end
                    end
                end
                PH_SIZE:
                begin
                    if (hex[DIGIT_W])
                    begin
                        nxt.chunk_count = acc;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        nxt.phase = (cur.chunk_count == '0) ? PH_DONE : PH_DATA;
                    end
                    else
                    begin
                        nxt.phase = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    if (in_byte == CH_LF)
                    begin
                        nxt.phase = (cur.chunk_count == '0) ? PH_DONE : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (cur.delivered_count < output_limit)
                    begin
                        valid               = 1'b1;
                        nxt.delivered_count = cur.delivered_count + COUNT_W'(1);
                    end
                    else
                    begin
                        nxt.dropped = 1'b1;
                    end
                    nxt.chunk_count = cur.chunk_count - CHUNK_W'(1);
                    if (cur.chunk_count == CHUNK_W'(1))
                    begin
                        nxt.phase = PH_SKIP;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign state_next        = nxt;
    assign result.data_valid = valid;
    assign result.data_byte  = valid ? in_byte : '0;
    assign result.finished   = (nxt.phase == PH_DONE);
    assign result.truncated  = nxt.dropped;

endmodule

`default_nettype wire

// ===== hw/rtl/http_chunked_body_decoder_core.sv =====
`default_nettype none

// channel   dir  payload                                       handshake
// in_ch     in   start_req, in_byte                            valid/ready
// out_ch    out  data_valid, data_byte, finished, truncated    valid/ready
// cfg       in   cfg_wr_data (output_limit)                    cfg_wr_en
//
// One result per request, one request per cycle sustained while out_ch is ready.
// A request passes through the input reg, then the result reg, before its result is valid.
// The decode state updates as a request moves from the input reg to the result reg.
// A stalled out_ch holds both stages; in_ch.ready drops once both are full.
// rst_n clears decode state, stage valids and sets output_limit to 65535.

module http_chunked_body_decoder_core
    import chb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    chb_in_if.sink             in_ch,
    chb_out_if.source          out_ch
);

    logic               in_valid_reg;
    logic               in_start_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    chb_result_t        out_reg;
    chb_state_t         state_reg;
    chb_state_t         state_next;
    chb_result_t        result_next;
    logic [COUNT_W-1:0] limit_reg;
    logic               advance;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    chb_step u_step (
        .state        (state_reg),
        .start_req    (in_start_reg),
        .in_byte      (in_byte_reg),
        .output_limit (limit_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_start_reg <= in_ch.start_req;
            in_byte_reg  <= in_ch.in_byte;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.data_valid = out_reg.data_valid;
    assign out_ch.data_byte  = out_reg.data_byte;
    assign out_ch.finished   = out_reg.finished;
    assign out_ch.truncated  = out_reg.truncated;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result reg not loaded after advance");

    a_data_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.data_valid) |-> !out_reg.finished)
        else $error("payload byte delivered with finished set");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.data_valid) |-> (out_reg.data_byte == '0))
        else $error("data_byte nonzero without data_valid");

    a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DATA) |-> (state_reg.chunk_count != '0))
        else $error("payload phase with zero bytes left");

endmodule

`default_nettype wire
